// File: hw/rtl/sbpa_pkg.sv
// ----------------------------------------------------------------------------
// sbpa_pkg
// Shared types and constants for the spectrum band power analyzer: field
// widths, band edges, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package sbpa_pkg;

  localparam int FREQ_W       = 16;
  localparam int MAG_W        = 24;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = 56;
  localparam int PWR_W        = 48;
  localparam int N_BANDS      = 5;
  localparam int BAND_IDX_W   = 3;
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int MAX_BINS_DEF = 256;

  // band edges in q12.4 hertz, both inclusive: delta, theta, alpha, beta, gamma
  localparam logic [N_BANDS-1:0][FREQ_W-1:0] BAND_LO =
    {16'd480, 16'd208, 16'd128, 16'd64, 16'd8};
  localparam logic [N_BANDS-1:0][FREQ_W-1:0] BAND_HI =
    {16'd1600, 16'd480, 16'd208, 16'd128, 16'd64};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_STORE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic div_load;
    logic div_step;
    logic div_store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_bin;
    logic div_last;
    logic band_last;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/sbpa_ctrl.sv
// ----------------------------------------------------------------------------
// sbpa_ctrl
// Controller: sequences input capture, squaring, band accumulation, the
// per-band mean division and the hand-off of a result to the output register.
// ----------------------------------------------------------------------------
module sbpa_ctrl
  import sbpa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SQUARE;
      end
      S_SQUARE: state_next = S_ACCUM;
      S_ACCUM: begin
        state_next = status.last_bin ? S_DIV_LOAD : S_IDLE;
      end
      S_DIV_LOAD: state_next = S_DIV_RUN;
      S_DIV_RUN: begin
        if (status.div_last) state_next = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        state_next = status.band_last ? S_EMIT : S_DIV_LOAD;
      end
      S_EMIT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_SQUARE:    cmd.square    = 1'b1;
      S_ACCUM:     cmd.accum     = 1'b1;
      S_DIV_LOAD:  cmd.div_load  = 1'b1;
      S_DIV_RUN:   cmd.div_step  = 1'b1;
      S_DIV_STORE: cmd.div_store = 1'b1;
      S_EMIT:      cmd.emit      = status.out_free;
      default:     cmd           = '0;
    endcase
  end

endmodule

// File: hw/rtl/sbpa_datapath.sv
// ----------------------------------------------------------------------------
// sbpa_datapath
// Datapath: input register, squarer, band sums and counts, peak tracker,
// a shared restoring divider (one quotient bit per cycle) and the output
// register with its valid flag.
// ----------------------------------------------------------------------------
module sbpa_datapath
  import sbpa_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic [FREQ_W-1:0]              bin_frequency,
  input  logic [MAG_W-1:0]               bin_magnitude,
  input  logic                           last_bin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [N_BANDS-1:0][PWR_W-1:0]  out_power,
  output logic [FREQ_W-1:0]              out_dominant
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam logic [CNT_W-1:0] MAX_POS = CNT_W'(MAX_BINS);

  logic [FREQ_W-1:0]              freq_r;
  logic [MAG_W-1:0]               mag_r;
  logic                           last_r;
  logic [SQ_W-1:0]                sq;
  logic [SQ_W-1:0]                sq_full;
  logic [N_BANDS-1:0][SUM_W-1:0]  band_sums;
  logic [N_BANDS-1:0][CNT_W-1:0]  band_counts;
  logic [MAG_W-1:0]               peak_magnitude;
  logic [FREQ_W-1:0]              peak_frequency;
  logic [CNT_W-1:0]               bin_position;
  logic [N_BANDS-1:0]             in_band;
  logic                           take;

  logic [BAND_IDX_W-1:0]          band_sel;
  logic [STEP_W-1:0]              step;
  logic [SUM_W-1:0]               quo;
  logic [CNT_W-1:0]               rem;
  logic [CNT_W-1:0]               divisor;
  logic [CNT_W:0]                 rem_sh;
  logic                           rem_ge;

  assign sq_full = SQ_W'(mag_r) * SQ_W'(mag_r);
  assign take    = (bin_position != MAX_POS);

  always_comb begin
    for (int b = 0; b < N_BANDS; b++) begin
      in_band[b] = (freq_r >= BAND_LO[b]) && (freq_r <= BAND_HI[b]);
    end
  end

  assign divisor = band_counts[band_sel];
  assign rem_sh  = {rem, quo[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});

  assign status.last_bin  = last_r;
  assign status.div_last  = (step == STEP_W'(SUM_W - 1));
  assign status.band_last = (band_sel == BAND_IDX_W'(N_BANDS - 1));
  assign status.out_free  = !out_valid || !out_stall;

  // input capture, product, divider and output data registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      freq_r <= bin_frequency;
      mag_r  <= bin_magnitude;
      last_r <= last_bin;
    end
    if (cmd.square) begin
      sq <= sq_full;
    end
    if (cmd.div_load) begin
      quo  <= band_sums[band_sel];
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
      step <= step + 1'b1;
    end
    if (cmd.emit) begin
      for (int b = 0; b < N_BANDS; b++) begin
        out_power[b] <= band_sums[b][PWR_W-1:0];
      end
      out_dominant <= peak_frequency;
    end
  end

  // frame state and out_valid; the quotient of each band, or zero for an empty band, replaces its sum
  always_ff @(posedge clk) begin
    if (rst) begin
      band_sums      <= '0;
      band_counts    <= '0;
      peak_magnitude <= '0;
      peak_frequency <= '0;
      bin_position   <= '0;
      band_sel       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.accum && take) begin
        for (int b = 0; b < N_BANDS; b++) begin
          if (in_band[b]) begin
            band_sums[b]   <= band_sums[b] + SUM_W'(sq);
            band_counts[b] <= band_counts[b] + 1'b1;
          end
        end
        if (bin_position != '0 && mag_r > peak_magnitude) begin
          peak_magnitude <= mag_r;
          peak_frequency <= freq_r;
        end
        bin_position <= bin_position + 1'b1;
      end
      if (cmd.div_store) begin
        band_sums[band_sel] <= (divisor == '0) ? '0 : SUM_W'(quo[PWR_W-1:0]);
        band_sel            <= band_sel + 1'b1;
      end
      if (cmd.emit) begin
        band_sums      <= '0;
        band_counts    <= '0;
        peak_magnitude <= '0;
        peak_frequency <= '0;
        bin_position   <= '0;
        band_sel       <= '0;
        out_valid      <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/spectrum_band_power_analyzer.sv
// ----------------------------------------------------------------------------
// spectrum_band_power_analyzer
// Per-frame band power (delta, theta, alpha, beta, gamma) and dominant
// frequency from a stream of spectrum bins.
//
//   channel   signals                                         direction
//   input     in_valid, in_stall, bin_frequency,              in
//             bin_magnitude, last_bin
//   output    out_valid, out_stall, delta_power, theta_power, out
//             alpha_power, beta_power, gamma_power,
//             dominant_frequency
//
// a bin passes through capture, square and accumulate in turn
// the last bin then runs the shared restoring divider over each band in turn,
// one quotient bit per cycle per band
// reset is synchronous and clears all frame state at once
// in_stall is low only in the idle state, where a bin is captured; a result waits in the output
// register while the next frame's bins are taken, and a new result that finds
// it still held keeps in_stall high until it moves in
// ----------------------------------------------------------------------------
module spectrum_band_power_analyzer
  import sbpa_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FREQ_W-1:0] bin_frequency,
  input  logic [MAG_W-1:0]  bin_magnitude,
  input  logic              last_bin,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PWR_W-1:0]  delta_power,
  output logic [PWR_W-1:0]  theta_power,
  output logic [PWR_W-1:0]  alpha_power,
  output logic [PWR_W-1:0]  beta_power,
  output logic [PWR_W-1:0]  gamma_power,
  output logic [FREQ_W-1:0] dominant_frequency
);

  cmd_t                          cmd;
  status_t                       status;
  logic [N_BANDS-1:0][PWR_W-1:0] out_power;

  sbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sbpa_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .bin_frequency (bin_frequency),
    .bin_magnitude (bin_magnitude),
    .last_bin      (last_bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_power     (out_power),
    .out_dominant  (dominant_frequency)
  );

  assign delta_power = out_power[0];
  assign theta_power = out_power[1];
  assign alpha_power = out_power[2];
  assign beta_power  = out_power[3];
  assign gamma_power = out_power[4];

endmodule
